// ===== rtl/topk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_pkg
// Shared types and constants for the top-K largest tracker.
// ----------------------------------------------------------------------------
package topk_pkg;

  localparam int K_ENTRIES = 16;
  localparam int MAX_OUT   = 16;
  localparam int N_OUT     = (K_ENTRIES < MAX_OUT) ? K_ENTRIES : MAX_OUT;
  localparam int IDX_W     = (K_ENTRIES > 1) ? $clog2(K_ENTRIES) : 1;
  localparam int SCORE_W   = 32;
  localparam int RANK_W    = 4;

  localparam logic signed [SCORE_W-1:0] FLOOR_Q16 = -32'sd65470464;

  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic                      op;
    logic signed [SCORE_W-1:0] score;
  } in_item_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] kept_value;
    logic [RANK_W-1:0]         rank;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic insert;
    logic cnt_clr;
    logic cnt_inc;
  } topk_cmd_t;

  typedef struct packed {
    logic last;
  } topk_status_t;

endpackage

// ===== rtl/topk_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_ctrl
// Sequencer: takes an item, then runs an insert or a readout of beats.
// ----------------------------------------------------------------------------
module topk_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  output logic                  out_valid,
  input  logic                  out_ready,
  output topk_pkg::topk_cmd_t   cmd,
  input  topk_pkg::topk_status_t status
);
  import topk_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INSERT = 2'd1;
  localparam logic [1:0] ST_EMIT   = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       in_fire, out_fire;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd.load    = 1'b0;
    cmd.insert  = 1'b0;
    cmd.cnt_clr = 1'b0;
    cmd.cnt_inc = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = (in_op == OP_READ) ? ST_EMIT : ST_INSERT;
        end
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_EMIT: begin
        if (out_fire) begin
          cmd.cnt_inc = 1'b1;
          if (status.last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/topk_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_dp
// Sorted register chain, largest first, with insert and readout counter.
// ----------------------------------------------------------------------------
module topk_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  topk_pkg::in_item_t     in_data,
  input  topk_pkg::topk_cmd_t    cmd,
  output topk_pkg::topk_status_t status,
  output topk_pkg::out_item_t    out_data
);
  import topk_pkg::*;

  logic signed [SCORE_W-1:0] store_r [K_ENTRIES];
  logic signed [SCORE_W-1:0] store_nxt [K_ENTRIES];
  logic signed [SCORE_W-1:0] score_r;
  logic [IDX_W-1:0]          cnt_r;
  logic [K_ENTRIES-1:0]      gt;

  // shift down from the insertion point, drop the smallest
  always_comb begin
    for (int i = 0; i < K_ENTRIES; i++) begin
      gt[i] = score_r > store_r[i];
    end
    for (int i = 0; i < K_ENTRIES; i++) begin
      if (!gt[i]) begin
        store_nxt[i] = store_r[i];
      end else if (i == 0) begin
        store_nxt[i] = score_r;
      end else if (gt[i-1]) begin
        store_nxt[i] = store_r[i-1];
      end else begin
        store_nxt[i] = score_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < K_ENTRIES; i++) store_r[i] <= FLOOR_Q16;
    end else if (cmd.insert) begin
      for (int i = 0; i < K_ENTRIES; i++) store_r[i] <= store_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) score_r <= in_data.score;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + IDX_W'(1);
    end
  end

  assign status.last         = (cnt_r == IDX_W'(N_OUT - 1));
  assign out_data.kept_value = store_r[cnt_r];
  assign out_data.rank       = RANK_W'(cnt_r);
  assign out_data.last       = status.last;

endmodule

// ===== rtl/top_k_largest_tracker_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_largest_tracker_core
// Keeps the K largest signed Q16.16 scores of a stream; reads them out sorted.
// ----------------------------------------------------------------------------
// The kept values live in a register chain held in descending order, all
// -999.0 after reset. In an add, the beat is taken, then every entry
// compares against the score at once and the chain shifts to insert it,
// dropping the smallest. In a read, the beat is taken, then the result beats
// follow (16 beats, largest first, rank 0 up, last on the final beat), each
// held while the output stalls; the readout walks the chain with one counter
// and leaves the contents unchanged. One item is worked on at a time.
// ----------------------------------------------------------------------------
module top_k_largest_tracker_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  topk_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output topk_pkg::out_item_t out_data
);
  import topk_pkg::*;

  topk_cmd_t    cmd;
  topk_status_t status;

  topk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_data.op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  topk_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .status   (status),
    .out_data (out_data)
  );

endmodule

// ===== tb/topk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topk_checker
// Watches both channels of the top-K tracker, predicts every readout beat
// from its own copy of the kept scores and compares each beat on arrival.
// ----------------------------------------------------------------------------
module topk_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  topk_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  topk_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import topk_pkg::*;

  logic signed [SCORE_W-1:0] kept_model [K_ENTRIES];
  out_item_t                 readout_q [$];
  int                        err_count = 0;

  always @(posedge clk) begin : watch
    logic signed [SCORE_W-1:0] ranked [K_ENTRIES];
    logic signed [SCORE_W-1:0] hold;
    out_item_t                 beat_exp;
    int                        low_slot;
    int                        j;
    if (!rst_n) begin
      for (int i = 0; i < K_ENTRIES; i++) kept_model[i] = FLOOR_Q16;
    end else begin
      if (in_valid && in_ready) begin
        if (in_data.op == OP_ADD) begin
          low_slot = 0;
          for (int i = 1; i < K_ENTRIES; i++)
            if (kept_model[i] < kept_model[low_slot]) low_slot = i;
          if (in_data.score > kept_model[low_slot]) kept_model[low_slot] = in_data.score;
        end else begin
          for (int i = 0; i < K_ENTRIES; i++) ranked[i] = kept_model[i];
          for (int i = 1; i < K_ENTRIES; i++) begin
            hold = ranked[i];
            j    = i;
            while (j > 0 && ranked[j-1] < hold) begin
              ranked[j] = ranked[j-1];
              j--;
            end
            ranked[j] = hold;
          end
          for (int i = 0; i < N_OUT; i++) begin
            beat_exp.kept_value = ranked[i];
            beat_exp.rank       = RANK_W'(i);
            beat_exp.last       = (i == N_OUT - 1);
            readout_q           = {readout_q, beat_exp};
          end
        end
      end
      if (out_valid && out_ready) begin
        if (readout_q.size() == 0) begin
          err_count++;
          $display("%0t: unexpected beat: actual value %0d rank %0d last %0b", $time,
                   out_data.kept_value, out_data.rank, out_data.last);
        end else begin
          beat_exp = readout_q.pop_front();
          if (out_data.kept_value !== beat_exp.kept_value || out_data.rank !== beat_exp.rank
              || out_data.last !== beat_exp.last) begin
            err_count++;
            $display("%0t: mismatch: expected value %0d rank %0d last %0b,",
                     $time, beat_exp.kept_value, beat_exp.rank, beat_exp.last,
                     " actual value %0d rank %0d last %0b",
                     out_data.kept_value, out_data.rank, out_data.last);
          end
        end
      end
    end
    fail_count <= err_count;
    pending    <= readout_q.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives adds and readouts into the top-K tracker with random gaps and
// output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import topk_pkg::*;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int N_RANDOM    = 500;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  logic      steady    = 1'b0;
  int        stall_left = 0;
  int        cycle_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  top_k_largest_tracker_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  topk_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // stall the result side now and then
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  task automatic send_beat(input logic op, input logic signed [SCORE_W-1:0] score);
    int       gap;
    in_item_t beat;
    gap = steady ? 0 : pick_gap();
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    beat.op    = op;
    beat.score = score;
    in_valid  <= 1'b1;
    in_data   <= beat;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    longint                    base;
    logic signed [SCORE_W-1:0] value;
    logic signed [SCORE_W-1:0] prev_value;
    int                        pick;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_beat(OP_READ, 32'sh0);
    send_beat(OP_ADD, FLOOR_Q16);
    send_beat(OP_ADD, 32'sh80000000);
    send_beat(OP_ADD, 32'sh7FFFFFFF);
    send_beat(OP_ADD, 32'sh0);
    send_beat(OP_ADD, 32'shFFFFFFFF);
    send_beat(OP_ADD, FLOOR_Q16 + 1);
    repeat (3) send_beat(OP_ADD, 32'sh00010000);
    send_beat(OP_READ, 32'shFFFFFFFF);
    send_beat(OP_ADD, FLOOR_Q16);
    send_beat(OP_ADD, 32'sh40000000);
    send_beat(OP_ADD, 32'sh00000001);
    send_beat(OP_ADD, 32'shC0000000);
    send_beat(OP_ADD, 32'sh55555555);
    send_beat(OP_ADD, 32'sh2AAAAAAA);
    send_beat(OP_ADD, 32'shFFFF0000);
    send_beat(OP_ADD, 32'sh0000FFFF);
    send_beat(OP_ADD, 32'sh7FFFFFFE);
    send_beat(OP_ADD, 32'sh12345678);
    send_beat(OP_ADD, 32'sh00010000);
    send_beat(OP_ADD, $urandom());
    send_beat(OP_READ, 32'sh55555555);

    base       = FLOOR_Q16;
    prev_value = FLOOR_Q16;
    for (int n = 0; n < N_RANDOM; n++) begin
      steady = ((n / 64) % 4 == 3);
      pick   = $urandom_range(0, 99);
      if (pick < 12) begin
        send_beat(OP_READ, $urandom());
      end else begin
        if (pick < 62) begin
          base  = base + $urandom_range(0, 524288);
          value = SCORE_W'(base + $urandom_range(0, 255) - 128);
        end else if (pick < 80) begin
          value = prev_value;
        end else if (pick < 92) begin
          value = $urandom() | 32'h80000000;
        end else begin
          value = $urandom();
        end
        prev_value = value;
        send_beat(OP_ADD, value);
      end
    end
    send_beat(OP_READ, $urandom());
    in_valid <= 1'b0;
    steady   = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
